// File: hdl/pcce_pkg.sv
package pcce_pkg;

	localparam int REG_W     = 24;
	localparam int NUM_REGS  = 5;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int CMD_W     = 7;
	localparam int STEER_W   = 3;
	localparam int PULSE_W   = 4;
	localparam int PHASE_W   = 4;

	localparam logic [CMD_W-1:0] INIT_CMD = 7'd100;

	localparam logic [2:0] REG_PULSE_HIGH = 3'd0;
	localparam logic [2:0] REG_GAP        = 3'd1;
	localparam logic [2:0] REG_STEER_MARK = 3'd2;
	localparam logic [2:0] REG_SPEED_MARK = 3'd3;
	localparam logic [2:0] REG_INIT       = 3'd4;

	localparam logic [REG_W-1:0] RST_PULSE_HIGH = 24'd100;
	localparam logic [REG_W-1:0] RST_GAP        = 24'd200;
	localparam logic [REG_W-1:0] RST_STEER_MARK = 24'd5000;
	localparam logic [REG_W-1:0] RST_SPEED_MARK = 24'd20000;
	localparam logic [REG_W-1:0] RST_INIT       = 24'd50000;

	localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
	localparam logic [PHASE_W-1:0] PH_S_HIGH  = 4'd1;
	localparam logic [PHASE_W-1:0] PH_S_GAP   = 4'd2;
	localparam logic [PHASE_W-1:0] PH_SM_HIGH = 4'd3;
	localparam logic [PHASE_W-1:0] PH_SM_GAP  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_P_HIGH  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_P_GAP   = 4'd6;
	localparam logic [PHASE_W-1:0] PH_PM_HIGH = 4'd7;
	localparam logic [PHASE_W-1:0] PH_PM_GAP  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_INIT    = 4'd9;

	typedef struct packed {
		logic             req_type;
		logic [CMD_W-1:0] command;
	} cmd_item_t;

	typedef struct packed {
		logic pin_level;
		logic busy_res;
		logic rejected;
	} res_item_t;

	typedef struct packed {
		logic [REG_W-1:0] pulse_high_ticks;
		logic [REG_W-1:0] gap_ticks;
		logic [REG_W-1:0] steer_mark_ticks;
		logic [REG_W-1:0] speed_mark_ticks;
		logic [REG_W-1:0] init_ticks;
	} cfg_regs_t;

endpackage

// File: hdl/pcce_cfg.sv
module pcce_cfg
	import pcce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_regs_t         regs
);

	cfg_regs_t   regs_q;
	logic [2:0]  idx;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign regs   = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pulse_high_ticks <= RST_PULSE_HIGH;
			regs_q.gap_ticks        <= RST_GAP;
			regs_q.steer_mark_ticks <= RST_STEER_MARK;
			regs_q.speed_mark_ticks <= RST_SPEED_MARK;
			regs_q.init_ticks       <= RST_INIT;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_PULSE_HIGH: regs_q.pulse_high_ticks <= pwdata[REG_W-1:0];
				REG_GAP:        regs_q.gap_ticks        <= pwdata[REG_W-1:0];
				REG_STEER_MARK: regs_q.steer_mark_ticks <= pwdata[REG_W-1:0];
				REG_SPEED_MARK: regs_q.speed_mark_ticks <= pwdata[REG_W-1:0];
				REG_INIT:       regs_q.init_ticks       <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PULSE_HIGH: prdata = DATA_W'(regs_q.pulse_high_ticks);
			REG_GAP:        prdata = DATA_W'(regs_q.gap_ticks);
			REG_STEER_MARK: prdata = DATA_W'(regs_q.steer_mark_ticks);
			REG_SPEED_MARK: prdata = DATA_W'(regs_q.speed_mark_ticks);
			REG_INIT:       prdata = DATA_W'(regs_q.init_ticks);
			default:        prdata = '0;
		endcase
	end

endmodule

// File: hdl/pcce_core.sv
module pcce_core
	import pcce_pkg::*;
#(
	parameter int COUNT_WIDTH = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_regs_t regs,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd_item,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_item
);

	localparam int XW = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

	function automatic logic [COUNT_WIDTH-1:0] clamp_len(input logic [REG_W-1:0] raw);
		logic [XW-1:0] ext;
		logic [XW-1:0] cmax;
		begin
			ext  = XW'(raw);
			cmax = XW'({COUNT_WIDTH{1'b1}});
			if (raw == '0) ext = XW'(1);
			if (ext > cmax) ext = cmax;
			clamp_len = COUNT_WIDTH'(ext);
		end
	endfunction

	logic [PHASE_W-1:0]     phase_q, phase_n;
	logic [PULSE_W-1:0]     pulses_left_q, pulses_left_n, pulses_dec;
	logic [PULSE_W-1:0]     speed_count_q, speed_count_n;
	logic [COUNT_WIDTH-1:0] tick_count_q, tick_count_n, tick_dec, load_len;
	logic                   entered;
	logic                   rej;
	logic                   accept;
	logic                   res_valid_q;
	res_item_t              res_q, res_n;

	assign cmd_stall  = res_valid_q && res_stall;
	assign accept     = cmd_valid && !cmd_stall;
	assign res_valid  = res_valid_q;
	assign res_item   = res_q;
	assign pulses_dec = pulses_left_q - PULSE_W'(1);
	assign tick_dec   = (tick_count_q != '0) ? tick_count_q - COUNT_WIDTH'(1) : tick_count_q;

	always_comb begin
		phase_n       = phase_q;
		pulses_left_n = pulses_left_q;
		speed_count_n = speed_count_q;
		tick_count_n  = tick_count_q;
		entered       = 1'b0;
		rej           = 1'b0;
		if (cmd_item.req_type) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else if (cmd_item.command == INIT_CMD) begin
				phase_n = PH_INIT;
				entered = 1'b1;
			end else begin
				pulses_left_n = PULSE_W'(cmd_item.command[STEER_W-1:0]);
				speed_count_n = cmd_item.command[CMD_W-1:STEER_W];
				phase_n = (cmd_item.command[STEER_W-1:0] != '0) ? PH_S_HIGH : PH_SM_HIGH;
				entered = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			tick_count_n = tick_dec;
			if (tick_dec == '0) begin
				entered = 1'b1;
				case (phase_q)
					PH_S_HIGH: phase_n = PH_S_GAP;
					PH_S_GAP: begin
						pulses_left_n = pulses_dec;
						phase_n = (pulses_dec != '0) ? PH_S_HIGH : PH_SM_HIGH;
					end
					PH_SM_HIGH: phase_n = PH_SM_GAP;
					PH_SM_GAP: begin
						pulses_left_n = speed_count_q;
						phase_n = (speed_count_q != '0) ? PH_P_HIGH : PH_PM_HIGH;
					end
					PH_P_HIGH: phase_n = PH_P_GAP;
					PH_P_GAP: begin
						pulses_left_n = pulses_dec;
						phase_n = (pulses_dec != '0) ? PH_P_HIGH : PH_PM_HIGH;
					end
					PH_PM_HIGH: phase_n = PH_PM_GAP;
					default:    phase_n = PH_IDLE;
				endcase
			end
		end

		case (phase_n)
			PH_S_HIGH, PH_P_HIGH:                      load_len = clamp_len(regs.pulse_high_ticks);
			PH_S_GAP, PH_SM_GAP, PH_P_GAP, PH_PM_GAP: load_len = clamp_len(regs.gap_ticks);
			PH_SM_HIGH:                                load_len = clamp_len(regs.steer_mark_ticks);
			PH_PM_HIGH:                                load_len = clamp_len(regs.speed_mark_ticks);
			PH_INIT:                                   load_len = clamp_len(regs.init_ticks);
			default:                                   load_len = '0;
		endcase
		if (entered) tick_count_n = load_len;

		res_n.pin_level = (phase_n == PH_S_HIGH) || (phase_n == PH_SM_HIGH) ||
		                  (phase_n == PH_P_HIGH) || (phase_n == PH_PM_HIGH) ||
		                  (phase_n == PH_INIT);
		res_n.busy_res  = (phase_n != PH_IDLE);
		res_n.rejected  = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			pulses_left_q <= '0;
			speed_count_q <= '0;
			tick_count_q  <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				phase_q       <= phase_n;
				pulses_left_q <= pulses_left_n;
				speed_count_q <= speed_count_n;
				tick_count_q  <= tick_count_n;
				res_valid_q   <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) res_q <= res_n;
	end

endmodule

// File: hdl/pulse_count_command_encoder.sv
// Channel   Direction  Handshake              Payload
// cmd       in         cmd_valid / cmd_stall  cmd_item (req_type, command)
// res       out        res_valid / res_stall  res_item (pin_level, busy_res, rejected)
// cfg       in         APB psel / penable     paddr, pwdata, prdata
//
// One item is accepted per cycle while cmd_stall is low; its result is registered and shows the cycle after.
// The sequencer state and the result register update together when an item is accepted.
// Reset clears the sequencer to idle and loads the register defaults.
// cmd_stall is high only while a result is held under res_stall.
module pulse_count_command_encoder
	import pcce_pkg::*;
#(
	parameter int COUNT_WIDTH = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cmd_item_t         cmd_item,
	output logic              res_valid,
	input  logic              res_stall,
	output res_item_t         res_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_regs_t regs;

	pcce_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.regs    (regs)
	);

	pcce_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("command side stalled without a held result");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> res_valid)
		else $error("accepted item produced no result");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.rejected |-> res_item.busy_res)
		else $error("rejected command while idle");

	a_pin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.pin_level |-> res_item.busy_res)
		else $error("pin high while idle");

endmodule

// File: test/pulse_count_command_encoder_tb.sv
module pulse_count_command_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcce_pkg::*;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_CMD  = 1'b1;

	localparam logic [2:0] REG_UNUSED_LO = 3'd5;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLDOFF_LEN    = 300;
	localparam int PHASE_ITEMS    = 225;

	typedef enum {MIX_ANY, MIX_INIT_ONLY, MIX_NO_INIT} cmd_mix_t;

	typedef struct packed {
		logic      chk;
		res_item_t res;
		cmd_item_t it;
	} dir_row_t;

	// Register setting for this table: pulse 1, gap 0 (one tick), steer mark 2,
	// speed mark 1, init 3.
	localparam int DIR_ROWS = 24;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		{1'b1, 3'b000, REQ_TICK, 7'h7F},
		{1'b1, 3'b110, REQ_CMD,  INIT_CMD},
		{1'b1, 3'b111, REQ_CMD,  7'd5},
		{1'b0, 3'b000, REQ_TICK, 7'h00},
		{1'b0, 3'b000, REQ_TICK, 7'h7F},
		{1'b1, 3'b000, REQ_TICK, 7'h00},
		{1'b1, 3'b110, REQ_CMD,  7'd0},
		{1'b0, 3'b000, REQ_TICK, 7'h55},
		{1'b0, 3'b000, REQ_TICK, 7'h2A},
		{1'b0, 3'b000, REQ_TICK, 7'h00},
		{1'b0, 3'b000, REQ_TICK, 7'h00},
		{1'b0, 3'b000, REQ_TICK, 7'h00},
		{1'b1, 3'b110, REQ_CMD,  7'd9},
		{1'b1, 3'b111, REQ_CMD,  7'd127},
		{1'b0, 3'b000, REQ_TICK, 7'h00},
		{1'b0, 3'b000, REQ_TICK, 7'h7F},
		{1'b0, 3'b000, REQ_TICK, 7'h00},
		{1'b0, 3'b000, REQ_TICK, 7'h00},
		{1'b0, 3'b000, REQ_TICK, 7'h00},
		{1'b0, 3'b000, REQ_TICK, 7'h00},
		{1'b0, 3'b000, REQ_TICK, 7'h00},
		{1'b1, 3'b111, REQ_CMD,  INIT_CMD},
		{1'b0, 3'b000, REQ_TICK, 7'h00},
		{1'b1, 3'b000, REQ_TICK, 7'h00}
	};

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	cmd_item_t         cmd_item  = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	res_item_t         res_item;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int fail_count    = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int dropped_seen  = 0;
	int seq_done      = 0;
	int reg_writes    = 0;
	int idle_cycles   = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int holdoff_cycles = 0;

	res_item_t pending_res [$];

	logic [PHASE_W-1:0] seq_phase   = PH_IDLE;
	logic [PULSE_W-1:0] pulses_todo = '0;
	logic [PULSE_W-1:0] speed_todo  = '0;
	logic [REG_W-1:0]   tick_left   = '0;
	logic [REG_W-1:0]   reg_copy [NUM_REGS];

	pulse_count_command_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item (cmd_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	function automatic logic [REG_W-1:0] span_of(input logic [2:0] idx);
		logic [REG_W-1:0] v;
		v = reg_copy[idx];
		if (v == '0) v = REG_W'(1);
		return v;
	endfunction

	task automatic start_phase(input logic [PHASE_W-1:0] p);
		seq_phase = p;
		case (p)
			PH_S_HIGH, PH_P_HIGH: tick_left = span_of(REG_PULSE_HIGH);
			PH_S_GAP, PH_SM_GAP, PH_P_GAP, PH_PM_GAP: tick_left = span_of(REG_GAP);
			PH_SM_HIGH: tick_left = span_of(REG_STEER_MARK);
			PH_PM_HIGH: tick_left = span_of(REG_SPEED_MARK);
			PH_INIT: tick_left = span_of(REG_INIT);
			default: tick_left = '0;
		endcase
	endtask

	task automatic end_phase();
		case (seq_phase)
			PH_S_HIGH: start_phase(PH_S_GAP);
			PH_S_GAP: begin
				pulses_todo = pulses_todo - 1'b1;
				start_phase((pulses_todo != '0) ? PH_S_HIGH : PH_SM_HIGH);
			end
			PH_SM_HIGH: start_phase(PH_SM_GAP);
			PH_SM_GAP: begin
				pulses_todo = speed_todo;
				start_phase((pulses_todo != '0) ? PH_P_HIGH : PH_PM_HIGH);
			end
			PH_P_HIGH: start_phase(PH_P_GAP);
			PH_P_GAP: begin
				pulses_todo = pulses_todo - 1'b1;
				start_phase((pulses_todo != '0) ? PH_P_HIGH : PH_PM_HIGH);
			end
			PH_PM_HIGH: start_phase(PH_PM_GAP);
			default: begin
				start_phase(PH_IDLE);
				seq_done++;
			end
		endcase
	endtask

	task automatic encode_item(input cmd_item_t it, output res_item_t r);
		r.rejected = 1'b0;
		if (it.req_type == REQ_CMD) begin
			if (seq_phase != PH_IDLE) begin
				r.rejected = 1'b1;
			end else if (it.command == INIT_CMD) begin
				start_phase(PH_INIT);
			end else begin
				pulses_todo = PULSE_W'(it.command[STEER_W-1:0]);
				speed_todo = it.command[CMD_W-1:STEER_W];
				start_phase((pulses_todo != '0) ? PH_S_HIGH : PH_SM_HIGH);
			end
		end else if (seq_phase != PH_IDLE) begin
			if (tick_left != '0) tick_left = tick_left - 1'b1;
			if (tick_left == '0) end_phase();
		end
		r.pin_level = (seq_phase == PH_S_HIGH) || (seq_phase == PH_SM_HIGH) ||
			(seq_phase == PH_P_HIGH) || (seq_phase == PH_PM_HIGH) || (seq_phase == PH_INIT);
		r.busy_res = (seq_phase != PH_IDLE);
	endtask

	task automatic send_item(input cmd_item_t it, input logic typed_ok, input res_item_t typed);
		res_item_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= it;
		do @(posedge clk); while (cmd_stall);
		encode_item(it, r);
		pending_res.push_back(typed_ok ? typed : r);
		items_sent++;
	endtask

	task automatic send_random(input cmd_mix_t mix);
		cmd_item_t it;
		logic idle;
		idle = (seq_phase == PH_IDLE);
		it.command = $urandom_range(0, 1) ? 7'($urandom_range(0, 23)) : 7'($urandom_range(0, 127));
		if (idle) it.req_type = ($urandom_range(99) < 60) ? REQ_CMD : REQ_TICK;
		else it.req_type = ($urandom_range(99) < 7) ? REQ_CMD : REQ_TICK;
		if (idle && it.req_type == REQ_CMD) begin
			if (mix == MIX_INIT_ONLY) begin
				it.command = INIT_CMD;
			end else if (mix == MIX_NO_INIT) begin
				if (it.command == INIT_CMD) it.command = CMD_W'(INIT_CMD + 1);
			end else if ($urandom_range(99) < 8) begin
				it.command = INIT_CMD;
			end
		end
		send_item(it, 1'b0, '0);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_res.size() != 0);
	endtask

	// Ticks the running sequence out so that register writes only happen when
	// the encoder is idle and nothing is in flight.
	task automatic settle_idle();
		cmd_item_t tick;
		tick.req_type = REQ_TICK;
		tick.command = '0;
		while (seq_phase != PH_IDLE) send_item(tick, 1'b0, '0);
		wait_drained();
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx < NUM_REGS) reg_copy[idx] = data[REG_W-1:0];
		reg_writes++;
	endtask

	task automatic check_readback();
		logic [DATA_W-1:0] got;
		for (int i = 0; i < NUM_REGS; i++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= ADDR_W'(i * 4);
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			got = prdata;
			psel <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
			if (got !== DATA_W'(reg_copy[i])) begin
				fail_count++;
				$display("%0t: register %0d expected %h, got %h", $time, i,
					DATA_W'(reg_copy[i]), got);
			end
		end
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s expected %b, got %b", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : res_check
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (res_item.rejected === 1'b1) dropped_seen++;
			if (pending_res.size() == 0) begin
				fail_count++;
				$display("%0t: result %b arrived with nothing expected", $time, res_item);
			end else begin
				want = pending_res.pop_front();
				check_field("pin_level", want.pin_level, res_item.pin_level);
				check_field("busy_res", want.busy_res, res_item.busy_res);
				check_field("rejected", want.rejected, res_item.rejected);
			end
		end
	end

	initial begin : res_side
		int hold;
		forever begin
			@(posedge clk);
			if (holdoff_cycles > 0) begin
				hold = holdoff_cycles;
				holdoff_cycles = 0;
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles.", idle_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		reg_copy[REG_PULSE_HIGH] = RST_PULSE_HIGH;
		reg_copy[REG_GAP] = RST_GAP;
		reg_copy[REG_STEER_MARK] = RST_STEER_MARK;
		reg_copy[REG_SPEED_MARK] = RST_SPEED_MARK;
		reg_copy[REG_INIT] = RST_INIT;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_readback();

		apb_write(REG_PULSE_HIGH, 32'd1);
		apb_write(REG_GAP, 32'd0);
		apb_write(REG_STEER_MARK, 32'd2);
		apb_write(REG_SPEED_MARK, 32'd1);
		apb_write(REG_INIT, 32'd3);
		apb_write(REG_UNUSED_LO, 32'h1234_5678);
		apb_write(REG_UNUSED_HI, 32'hFFFF_FFFF);
		check_readback();
		for (int r = 0; r < DIR_ROWS; r++)
			send_item(DIR_TABLE[r].it, DIR_TABLE[r].chk, DIR_TABLE[r].res);
		settle_idle();

		apb_write(REG_PULSE_HIGH, 32'hFFFF_FFFF);
		apb_write(REG_GAP, 32'hFFFF_FFFF);
		apb_write(REG_STEER_MARK, 32'hFFFF_FFFF);
		apb_write(REG_SPEED_MARK, 32'hFFFF_FFFF);
		apb_write(REG_INIT, 32'd0);
		check_readback();
		repeat (30) send_random(MIX_INIT_ONLY);
		settle_idle();

		apb_write(REG_PULSE_HIGH, 32'd0);
		apb_write(REG_GAP, 32'd1);
		apb_write(REG_STEER_MARK, 32'd0);
		apb_write(REG_SPEED_MARK, 32'd1);
		apb_write(REG_INIT, 32'h00FF_FFFF);
		check_readback();
		repeat (60) send_random(MIX_NO_INIT);

		for (int p = 0; p < 4; p++) begin
			settle_idle();
			case (p)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 79;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 79;
				end
				default: begin
					send_idle_pct = 23;
					stall_pct = 23;
				end
			endcase
			apb_write(REG_PULSE_HIGH, $urandom_range(0, 3));
			apb_write(REG_GAP, $urandom_range(0, 3));
			apb_write(REG_STEER_MARK, $urandom_range(0, 4));
			apb_write(REG_SPEED_MARK, $urandom_range(0, 4));
			apb_write(REG_INIT, $urandom_range(0, 6));
			if (p == 0) holdoff_cycles = HOLDOFF_LEN;
			repeat (PHASE_ITEMS) send_random(MIX_ANY);
			if (p == 1) wait_drained();
			repeat (PHASE_ITEMS) send_random(MIX_ANY);
		end
		settle_idle();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d items and checked %0d results, %0d of them dropped commands.",
			items_sent, results_seen, dropped_seen);
		$display("Finished %0d pulse sequences over %0d register writes and four idling mixes.",
			seq_done, reg_writes);
		if (fail_count == 0 && pending_res.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
